/* src/assert_macros.svh */
// assertion macros for the rtl files, used by the top level
// needs clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define DTU_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define DTU_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

/* src/dtu_pkg.sv */
// types and constants of the depth texel unprojection block
// no dependencies
package dtu_pkg;

  localparam int QUO_BITS = 32;

  localparam logic [2:0] REG_NEAR   = 3'd0;
  localparam logic [2:0] REG_FAR    = 3'd1;
  localparam logic [2:0] REG_LEFT   = 3'd2;
  localparam logic [2:0] REG_RIGHT  = 3'd3;
  localparam logic [2:0] REG_UP     = 3'd4;
  localparam logic [2:0] REG_DOWN   = 3'd5;
  localparam logic [2:0] REG_WIDTH  = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CFG  = 3'd1,
    ST_LIN_FAIL = 3'd2,
    ST_TOO_NEAR = 3'd3,
    ST_OUTSIDE  = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  typedef struct packed {
    logic v;
    logic bad;
    logic lin_fail;
    logic outside;
  } side_t;

endpackage

/* src/dtu_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on dtu_pkg; quotient must fit in QUO_BITS bits
module dtu_div import dtu_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 33
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NW-1:0]       num,
  input  logic [DW-1:0]       den,
  output logic [QUO_BITS-1:0] quo
);

  localparam int CW = (DW + QUO_BITS > NW) ? DW + QUO_BITS : NW;

  logic [CW-1:0]       rem   [QUO_BITS];
  logic [DW-1:0]       den_r [QUO_BITS];
  logic [QUO_BITS-1:0] q     [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    logic [CW-1:0]       rem_in;
    logic [DW-1:0]       den_in;
    logic [QUO_BITS-1:0] q_in;
    logic [CW-1:0]       shifted;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_in = CW'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q[k-1];
    end

    assign shifted = CW'(den_in) << (QUO_BITS - 1 - k);
    assign ge      = rem_in >= shifted;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= ge ? rem_in - shifted : rem_in;
        den_r[k] <= den_in;
        q[k]     <= q_in | (QUO_BITS'(ge) << (QUO_BITS - 1 - k));
      end
    end
  end

  assign quo = q[QUO_BITS-1];

endmodule

/* src/depth_texel_unproject_top.sv */
// depth texel unprojection top level: config registers and the item pipeline
// depends on dtu_pkg, dtu_div and assert_macros.svh
//
// Takes one depth texel per clock while in_stall is low and returns one
// view-space point per texel, in order. The pipeline is built around the depth and
// tangent dividers, which resolve one quotient bit per stage over 32 stages,
// plus two stages in front for the plane products and operand setup and two
// behind for the tangent multiply and range checks. The whole pipeline holds
// while a finished word waits under out_stall. Configuration writes are always
// ready and must only be made while no word is in flight.
`include "assert_macros.svh"
module depth_texel_unproject_top import dtu_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int DEPTH_BITS = 24,
  parameter int MIN_DEPTH  = 6554
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        texel_col,
  input  logic [11:0]        texel_row,
  input  logic [23:0]        stored_depth,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic [2:0]         status
);

  localparam int SMW = DEPTH_BITS + 32;

  logic [31:0]        near_plane, far_plane;
  logic signed [23:0] tan_left, tan_right, tan_up, tan_down;
  logic [12:0]        image_width, image_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_plane   <= 32'd6554;
      far_plane    <= 32'd0;
      tan_left     <= -24'sd1048576;
      tan_right    <= 24'sd1048576;
      tan_up       <= 24'sd1048576;
      tan_down     <= -24'sd1048576;
      image_width  <= 13'd320;
      image_height <= 13'd320;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NEAR:   near_plane   <= cfg_data;
        REG_FAR:    far_plane    <= cfg_data;
        REG_LEFT:   tan_left     <= cfg_data[23:0];
        REG_RIGHT:  tan_right    <= cfg_data[23:0];
        REG_UP:     tan_up       <= cfg_data[23:0];
        REG_DOWN:   tan_down     <= cfg_data[23:0];
        REG_WIDTH:  image_width  <= cfg_data[12:0];
        REG_HEIGHT: image_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // config checks; the user must keep them static while words are in flight, the block does not enforce it
  logic cfg_bad, inf_far;
  logic [24:0] dx_tan, dy_tan;
  assign inf_far = far_plane == 32'd0;
  assign cfg_bad = near_plane == 32'd0 ||
                   (!inf_far && far_plane <= near_plane) ||
                   image_width == 13'd0 || 15'(image_width) > 15'(MAX_DIM) ||
                   image_height == 13'd0 || 15'(image_height) > 15'(MAX_DIM) ||
                   tan_right <= tan_left || tan_up <= tan_down;
  assign dx_tan = {tan_right[23], tan_right} - {tan_left[23], tan_left};
  assign dy_tan = {tan_up[23], tan_up} - {tan_down[23], tan_down};

  logic [31:0]           sd_wide;
  logic [DEPTH_BITS-1:0] sd;
  assign sd_wide = {8'd0, stored_depth};
  assign sd      = sd_wide[DEPTH_BITS-1:0];

  // stage 1: products
  logic                  v1, bad1, out1;
  logic [63:0]           nf1;
  logic [SMW-1:0]        sm1;
  logic [DEPTH_BITS-1:0] sd1;
  logic [37:0]           nx1, ny1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad1 <= cfg_bad;
      out1 <= {1'b0, texel_col} >= image_width || {1'b0, texel_row} >= image_height;
      nf1  <= 64'(near_plane) * 64'(far_plane);
      sm1  <= SMW'(sd) * SMW'(far_plane - near_plane);
      sd1  <= sd;
      nx1  <= 38'({texel_col, 1'b1}) * 38'(dx_tan);
      ny1  <= 38'({texel_row, 1'b1}) * 38'(dy_tan);
    end
  end

  // stage 2: divider operands
  logic        v2, bad2, out2, ovf2;
  logic [63:0] n2;
  logic [32:0] d2;
  logic [37:0] numx2;
  logic [38:0] numy2;
  logic [13:0] dx2, dy2;

  logic [31:0] sub1;
  logic [63:0] n_next;
  logic [32:0] d_next;
  assign sub1   = sm1[SMW-1:DEPTH_BITS];
  assign n_next = inf_far ? ({32'd0, near_plane} << DEPTH_BITS) : nf1;
  assign d_next = inf_far ? ((33'd1 << DEPTH_BITS) - 33'(sd1))
                          : 33'(far_plane - sub1);

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad2  <= bad1;
      out2  <= out1;
      n2    <= n_next;
      d2    <= d_next;
      ovf2  <= {1'b0, n_next} >= {d_next, 32'd0};
      numx2 <= nx1;
      numy2 <= 39'(ny1) + 39'({image_height, 1'b0} - 14'd1);
      dx2   <= {image_width, 1'b0};
      dy2   <= {image_height, 1'b0};
    end
  end

  logic [QUO_BITS-1:0] qd, qx, qy;

  dtu_div #(.NW(64), .DW(33)) u_div_depth (
    .clk(clk), .en(adv), .num(n2), .den(d2), .quo(qd)
  );
  dtu_div #(.NW(38), .DW(14)) u_div_x (
    .clk(clk), .en(adv), .num(numx2), .den(dx2), .quo(qx)
  );
  dtu_div #(.NW(39), .DW(14)) u_div_y (
    .clk(clk), .en(adv), .num(numy2), .den(dy2), .quo(qy)
  );

  side_t side_pipe [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_side
    side_t side_in;
    if (k == 0) begin : g_first
      assign side_in = '{v: v2, bad: bad2, lin_fail: ovf2, outside: out2};
    end else begin : g_rest
      assign side_in = side_pipe[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) side_pipe[k] <= '0;
      else if (adv) side_pipe[k] <= side_in;
    end
  end

  side_t side_d;
  assign side_d = side_pipe[QUO_BITS-1];

  // stage 3: tangents times depth
  logic signed [25:0] tx, ty;
  logic signed [32:0] dz;
  assign tx = 26'(tan_left) + $signed({1'b0, qx[24:0]});
  assign ty = 26'(tan_up) - $signed({1'b0, qy[24:0]});
  assign dz = $signed({1'b0, qd});

  logic               v3;
  logic signed [58:0] prodx3, prody3;
  logic [31:0]        depth3;
  status_t            pre3, pre_next;

  always_comb begin
    pre_next = ST_OK;
    if (side_d.bad) pre_next = ST_BAD_CFG;
    else if (side_d.lin_fail) pre_next = ST_LIN_FAIL;
    else if (qd < 32'(MIN_DEPTH)) pre_next = ST_TOO_NEAR;
    else if (side_d.outside) pre_next = ST_OUTSIDE;
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= side_d.v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prodx3 <= tx * dz;
      prody3 <= ty * dz;
      depth3 <= qd;
      pre3   <= pre_next;
    end
  end

  // stage 4: range checks and output word
  logic signed [58:0] sx, sy;
  logic               ovf4;
  status_t            st4;
  assign sx   = prodx3 >>> 20;
  assign sy   = prody3 >>> 20;
  assign ovf4 = sx[58:31] != {28{sx[31]}} || sy[58:31] != {28{sy[31]}} ||
                depth3 > 32'h8000_0000;
  assign st4  = (pre3 == ST_OK && ovf4) ? ST_OVERFLOW : pre3;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status  <= st4;
      point_x <= (st4 == ST_OK) ? sx[31:0] : 32'sd0;
      point_y <= (st4 == ST_OK) ? sy[31:0] : 32'sd0;
      point_z <= (st4 == ST_OK) ? -$signed(depth3) : 32'sd0;
    end
  end

  `DTU_IMPLY(a_fail_zero, out_valid && status != ST_OK,
             point_x == 32'sd0 && point_y == 32'sd0 && point_z == 32'sd0)
  `DTU_IMPLY(a_ok_depth, out_valid && status == ST_OK,
             point_z <= -$signed(33'(MIN_DEPTH)))
  `DTU_ASSERT(a_stall_link, in_stall == (out_valid && out_stall))

endmodule

/* test/tb.sv */
// testbench for depth_texel_unproject_top: random and directed depth texels
// checked against a built-in predictor; depends on dtu_pkg and the rtl
`timescale 1ns / 1ps
module tb import dtu_pkg::*; ();

  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic [23:0] sd;
  } texel_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    status_t st;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_NEAR;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] texel_col = '0;
  logic [11:0] texel_row = '0;
  logic [23:0] stored_depth = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] point_x, point_y, point_z;
  logic [2:0] status;

  depth_texel_unproject_top dut (.*);

  always #5 clk = ~clk;

  // shadow configuration
  logic [31:0] near_q16 = 32'd6554;
  logic [31:0] far_q16 = 32'd0;
  logic signed [23:0] tl = -24'sd1048576, tr = 24'sd1048576;
  logic signed [23:0] tu = 24'sd1048576, td = -24'sd1048576;
  logic [12:0] img_w = 13'd320, img_h = 13'd320;

  texel_t pending_texels[$];
  point_t expected_points[$];
  int errors = 0;
  int cycles = 0;
  bit took = 0;
  int gap_left = 0;
  int stall_left = 0;
  int long_left = 0;
  bit long_req = 0, long_done = 0;
  bit no_idle = 0;

  function automatic longint floor_div(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint view_tangent(longint lo, longint hi, longint idx, longint size);
    longint twice;
    twice = size * 2;
    return floor_div(lo * twice + (2 * idx + 1) * (hi - lo), twice);
  endfunction

  function automatic point_t unproject(texel_t t);
    point_t p;
    logic [63:0] dep, sub, den;
    longint tx, ty, dz, px, py;
    p.x = 0; p.y = 0; p.z = 0; p.st = ST_OK;
    if (near_q16 == 0 || (far_q16 != 0 && far_q16 <= near_q16) || img_w == 0 ||
        img_w > 4096 || img_h == 0 || img_h > 4096 || tr <= tl || tu <= td) begin
      p.st = ST_BAD_CFG;
      return p;
    end
    if (far_q16 == 0) begin
      dep = ({32'd0, near_q16} << 24) / (64'd16777216 - {40'd0, t.sd});
    end else begin
      sub = ({40'd0, t.sd} * {32'd0, far_q16 - near_q16}) >> 24;
      den = {32'd0, far_q16} - sub;
      dep = ({32'd0, near_q16} * {32'd0, far_q16}) / den;
    end
    if (dep > 64'hFFFF_FFFF) p.st = ST_LIN_FAIL;
    else if (dep < 64'd6554) p.st = ST_TOO_NEAR;
    else if (t.col >= img_w || t.row >= img_h) p.st = ST_OUTSIDE;
    else begin
      tx = view_tangent(longint'(tl), longint'(tr), longint'(t.col), longint'(img_w));
      ty = view_tangent(longint'(tu), longint'(td), longint'(t.row), longint'(img_h));
      dz = longint'(dep);
      px = floor_div(tx * dz, 64'sd1048576);
      py = floor_div(ty * dz, 64'sd1048576);
      if (px < -64'sd2147483648 || px > 64'sd2147483647 || py < -64'sd2147483648 ||
          py > 64'sd2147483647 || dz > 64'sd2147483648) p.st = ST_OVERFLOW;
      else begin
        p.x = px[31:0]; p.y = py[31:0]; p.z = 32'(-dz);
      end
    end
    return p;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  // monitor
  always @(posedge clk) begin
    point_t e;
    cycles <= cycles + 1;
    if (!rst && in_valid && !in_stall) begin
      expected_points.push_back(unproject('{texel_col, texel_row, stored_depth}));
      took = 1;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) report("unexpected word", status, -1);
      else begin
        e = expected_points.pop_front();
        if (status !== e.st) report("status", status, e.st);
        if (point_x !== e.x) report("point_x", point_x, e.x);
        if (point_y !== e.y) report("point_y", point_y, e.y);
        if (point_z !== e.z) report("point_z", point_z, e.z);
      end
    end
  end

  // driver
  always @(negedge clk) begin
    texel_t t;
    if (!rst && (!in_valid || took)) begin
      took = 0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!no_idle && in_valid && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (pending_texels.size() > 0) begin
        t = pending_texels.pop_front();
        in_valid <= 1'b1;
        texel_col <= t.col;
        texel_row <= t.row;
        stored_depth <= t.sd;
      end else in_valid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (long_req && !long_done) begin
      long_done = 1;
      long_left = 300;
    end
    if (long_left > 0) begin
      long_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NEAR:   near_q16 = val;
      REG_FAR:    far_q16 = val;
      REG_LEFT:   tl = val[23:0];
      REG_RIGHT:  tr = val[23:0];
      REG_UP:     tu = val[23:0];
      REG_DOWN:   td = val[23:0];
      REG_WIDTH:  img_w = val[12:0];
      REG_HEIGHT: img_h = val[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic cfg_all(logic [31:0] nr, logic [31:0] fr, logic [23:0] l, logic [23:0] r,
                         logic [23:0] u, logic [23:0] d, logic [12:0] w, logic [12:0] h);
    cfg_write(REG_NEAR, nr);
    cfg_write(REG_FAR, fr);
    cfg_write(REG_LEFT, {8'd0, l});
    cfg_write(REG_RIGHT, {8'd0, r});
    cfg_write(REG_UP, {8'd0, u});
    cfg_write(REG_DOWN, {8'd0, d});
    cfg_write(REG_WIDTH, {19'd0, w});
    cfg_write(REG_HEIGHT, {19'd0, h});
  endtask

  task automatic drain();
    wait (pending_texels.size() == 0 && !in_valid && expected_points.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_texel(logic [11:0] c, logic [11:0] r, logic [23:0] s);
    pending_texels.push_back('{c, r, s});
  endtask

  task automatic random_texels(int n);
    logic [11:0] c, r;
    logic [23:0] s;
    repeat (n) begin
      c = 12'(($urandom_range(0, 7) == 0 || img_w == 0) ? $urandom :
          $urandom_range(0, (img_w > 4096 ? 4096 : img_w) - 1));
      r = 12'(($urandom_range(0, 7) == 0 || img_h == 0) ? $urandom :
          $urandom_range(0, (img_h > 4096 ? 4096 : img_h) - 1));
      case ($urandom_range(0, 3))
        0: s = 24'($urandom_range(0, 255));
        1: s = 24'(24'hFFFFFF - $urandom_range(0, 255));
        default: s = 24'($urandom);
      endcase
      add_texel(c, r, s);
    end
  endtask

  task automatic random_cfg();
    logic [31:0] nr, fr;
    logic signed [23:0] l, r, u, d;
    logic [12:0] w, h;
    nr = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 32'h0004_0000);
    case ($urandom_range(0, 3))
      0, 1: fr = 0;
      2: fr = nr + $urandom_range(1, 32'h0100_0000);
      default: fr = $urandom;
    endcase
    if (fr != 0 && fr < nr) fr = 0;
    l = 24'(-$urandom_range(0, 24'h3FFFFF));
    r = 24'(l + $urandom_range(1, 24'h3FFFFF));
    d = 24'(-$urandom_range(0, 24'h3FFFFF));
    u = 24'(d + $urandom_range(1, 24'h3FFFFF));
    w = 13'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4096));
    h = 13'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4096));
    if ($urandom_range(0, 9) == 0)
      w = 13'($urandom_range(0, 1) ? 0 : $urandom_range(4097, 8191));
    cfg_all(nr, fr, l, r, u, d, w, h);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values, infinite far plane
    add_texel(0, 0, 0);
    add_texel(319, 319, 24'h800000);
    add_texel(160, 160, 24'hFFFFFF);
    add_texel(320, 0, 24'h100000);
    add_texel(0, 320, 24'h100000);
    add_texel(12'hFFF, 12'hFFF, 24'hFFFFFF);
    long_req = 1;
    random_texels(40);
    drain();

    // too near, finite planes
    cfg_all(32'd100, 32'h0000_0200, -24'sd1048576, 24'sd1048576, 24'sd1048576,
            -24'sd1048576, 13'd320, 13'd320);
    add_texel(5, 5, 0);
    add_texel(5, 5, 24'hFFFFFF);
    drain();
    // bad configurations
    cfg_all(32'd0, 32'd0, -24'sd1048576, 24'sd1048576, 24'sd1048576, -24'sd1048576,
            13'd4096, 13'd4096);
    add_texel(1, 1, 24'h400000);
    drain();
    cfg_write(REG_NEAR, 32'h0001_0000);
    cfg_write(REG_FAR, 32'h0001_0000);
    add_texel(1, 1, 24'h400000);
    drain();
    cfg_write(REG_FAR, 32'hFFFF_FFFF);
    cfg_write(REG_WIDTH, 32'd4097);
    add_texel(1, 1, 24'h400000);
    drain();
    cfg_write(REG_WIDTH, 32'd4096);
    cfg_write(REG_RIGHT, {8'd0, -24'sd1048576});
    add_texel(1, 1, 24'h400000);
    drain();
    cfg_write(REG_RIGHT, 32'h0080_0000 - 1);
    cfg_write(REG_UP, {8'd0, -24'sd1048576});
    add_texel(1, 1, 24'h400000);
    drain();
    // overflow with extreme tangents and planes
    cfg_all(32'hFFFF_FFFF, 32'd0, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
            13'd1, 13'd1);
    add_texel(0, 0, 0);
    add_texel(0, 0, 24'h000001);
    drain();
    cfg_all(32'h8000_0000, 32'hFFFF_FFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
            13'd4096, 13'd4096);
    add_texel(0, 0, 0);
    add_texel(12'hFFF, 12'hFFF, 24'hFFFFFF);
    add_texel(2048, 2048, 24'h7FFFFF);
    drain();

    repeat (10) begin
      random_cfg();
      random_texels(50);
      drain();
    end
    no_idle = 1;
    random_cfg();
    random_texels(60);
    drain();

    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
